/* hdl/cdo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date offset package
// Field widths, pipeline depth, status codes and the calendar tables used
// by the forward (date to day number) and inverse (day number to date) paths.
// ----------------------------------------------------------------------------
package cdo_pkg;

  // Default year window
  localparam int FIRST_YEAR_DEF = 1800;
  localparam int LAST_YEAR_DEF  = 9999;

  // Field widths
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int OFF_W  = 22;
  localparam int WDAY_W = 3;
  localparam int SER_W  = 22;

  // Absolute day count (from 0000-03-01) and signed target sum widths
  localparam int ABS_W  = 22;
  localparam int SUM_W  = 25;

  // Pipeline depth: forward stages, then inverse stages up to the output
  localparam int FWD_STAGES = 3;
  localparam int STAGES     = 11;

  localparam int DAYS_PER_ERA = 146097;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  // Transaction handed from the forward path to the inverse path
  typedef struct packed {
    logic signed [SUM_W-1:0] target;
    logic                    bad;
  } cdo_day_t;

  // Absolute day number of a date, used for elaboration constants only
  function automatic logic [ABS_W-1:0] abs_day_f(input int y_i, input int m_i,
                                                 input int d_i);
    int y;
    int mp;
    int era;
    int yoe;
    int doy;
    int doe;
    y   = (m_i <= 2) ? y_i - 1 : y_i;
    era = y / 400;
    yoe = y - era * 400;
    mp  = (m_i > 2) ? m_i - 3 : m_i + 9;
    doy = (153 * mp + 2) / 5 + d_i - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return ABS_W'(era * DAYS_PER_ERA + doe);
  endfunction

  // Month index counted from March (March is 0, February is 11)
  function automatic logic [3:0] march_month_f(input logic [MON_W-1:0] m);
    return (m > 4'd2) ? m - 4'd3 : m + 4'd9;
  endfunction

  // First day of a March-based month within the shifted year
  function automatic logic [8:0] march_start_f(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Length of a calendar month
  function automatic logic [DAY_W-1:0] month_len_f(input logic [MON_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/cdo_to_day.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forward path: date check and conversion to a day number
// Three stages: divide the year by 100, check the date and sum the year days,
// then add the month start, the day and the signed offset.
// ----------------------------------------------------------------------------
module cdo_to_day
  import cdo_pkg::*;
#(
  parameter int FIRST_YEAR = FIRST_YEAR_DEF,
  parameter int LAST_YEAR  = LAST_YEAR_DEF
) (
  input  logic                     clk,
  input  logic [FWD_STAGES-1:0]    en,
  input  logic [DAY_W-1:0]         day,
  input  logic [MON_W-1:0]         month,
  input  logic [YEAR_W-1:0]        year,
  input  logic signed [OFF_W-1:0]  offset,
  output cdo_day_t                 day_o
);

  localparam logic [YEAR_W-1:0] FY = YEAR_W'(FIRST_YEAR);
  localparam logic [YEAR_W-1:0] LY = YEAR_W'(LAST_YEAR);

  // Year / 100 by reciprocal multiply, exact for any 14-bit year
  localparam int     Q100_S  = 21;
  localparam int     Q100_MW = 15;
  localparam int     Q100_PW = YEAR_W + Q100_MW;
  localparam longint Q100_M  = ((longint'(1) << Q100_S) + 100 - 1) / 100;

  localparam int DAYS_W = 23;

  typedef struct packed {
    logic [DAY_W-1:0]        day;
    logic [MON_W-1:0]        month;
    logic [YEAR_W-1:0]       year;
    logic [YEAR_W-1:0]       yp;
    logic [7:0]              q100y;
    logic [7:0]              q100p;
    logic [8:0]              md;
    logic signed [OFF_W-1:0] off;
  } s1_t;

  typedef struct packed {
    logic [DAYS_W-1:0]       days;
    logic [8:0]              md;
    logic signed [OFF_W-1:0] off;
    logic                    valid;
  } s2_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  cdo_day_t s3_r, s3_nxt;

  logic [Q100_PW-1:0] prod_y;
  logic [Q100_PW-1:0] prod_p;
  logic [14:0]        hund_y;
  logic               cent;
  logic               leap;
  logic [DAY_W-1:0]   mlen;

  // Stage 1: shift the year for January and February, divide by 100
  always_comb begin
    s1_nxt.day   = day;
    s1_nxt.month = month;
    s1_nxt.year  = year;
    s1_nxt.yp    = (month <= 4'd2) ? year - 14'd1 : year;
    prod_y       = Q100_PW'(year) * Q100_PW'(Q100_M);
    prod_p       = Q100_PW'(s1_nxt.yp) * Q100_PW'(Q100_M);
    s1_nxt.q100y = prod_y[Q100_PW-1:Q100_S];
    s1_nxt.q100p = prod_p[Q100_PW-1:Q100_S];
    s1_nxt.md    = march_start_f(march_month_f(month)) + 9'(day) - 9'd1;
    s1_nxt.off   = offset;
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
  end

  // Stage 2: leap rule, date check and days before the shifted year
  always_comb begin
    hund_y = 15'(s1_r.q100y) * 15'd100;
    cent   = (hund_y == 15'(s1_r.year));
    leap   = ((s1_r.year[1:0] == 2'd0) && !cent) || (cent && (s1_r.q100y[1:0] == 2'd0));
    mlen   = month_len_f(s1_r.month, leap);
    s2_nxt.valid = (s1_r.year >= FY) && (s1_r.year <= LY) &&
                   (s1_r.month >= 4'd1) && (s1_r.month <= 4'd12) &&
                   (s1_r.day >= 5'd1) && (s1_r.day <= mlen);
    s2_nxt.days  = DAYS_W'(s1_r.yp) * DAYS_W'(365) + DAYS_W'(s1_r.yp >> 2)
                   - DAYS_W'(s1_r.q100p) + DAYS_W'(s1_r.q100p >> 2);
    s2_nxt.md    = s1_r.md;
    s2_nxt.off   = s1_r.off;
  end

  always_ff @(posedge clk) begin
    if (en[1]) s2_r <= s2_nxt;
  end

  // Stage 3: add month start, day and signed offset
  always_comb begin
    s3_nxt.target = $signed(SUM_W'(s2_r.days)) + $signed(SUM_W'(s2_r.md)) +
                    SUM_W'(s2_r.off);
    s3_nxt.bad    = !s2_r.valid;
  end

  always_ff @(posedge clk) begin
    if (en[2]) s3_r <= s3_nxt;
  end

  assign day_o = s3_r;

endmodule

/* hdl/cdo_from_day.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse path: range check and conversion of a day number back to a date
// Eight stages: era split, day of era, year of era, day of year, month and
// day, with the weekday and the serial day number carried alongside.
// ----------------------------------------------------------------------------
module cdo_from_day
  import cdo_pkg::*;
#(
  parameter int FIRST_YEAR = FIRST_YEAR_DEF,
  parameter int LAST_YEAR  = LAST_YEAR_DEF
) (
  input  logic                          clk,
  input  logic [STAGES-FWD_STAGES-1:0]  en,
  input  cdo_day_t                      day_i,
  output logic [DAY_W-1:0]              day_out,
  output logic [MON_W-1:0]              month_out,
  output logic [YEAR_W-1:0]             year_out,
  output logic [WDAY_W-1:0]             weekday,
  output logic [SER_W-1:0]              day_serial,
  output status_t                       status
);

  localparam logic [ABS_W-1:0] BASE = abs_day_f(FIRST_YEAR, 1, 1);
  localparam logic [ABS_W-1:0] LAST = abs_day_f(LAST_YEAR, 12, 31);

  localparam int DOE_W = 18;
  localparam int YOE_W = 9;
  localparam int DOY_W = 9;

  // Reciprocal multipliers; shift = dividend bits + divisor bits keeps them exact
  localparam int     ERA_S  = 40;
  localparam int     ERA_PW = ABS_W + 23;
  localparam longint ERA_M  = ((longint'(1) << ERA_S) + DAYS_PER_ERA - 1) / DAYS_PER_ERA;
  localparam int     Q7_S   = 25;
  localparam int     Q7_PW  = ABS_W + 23;
  localparam longint Q7_M   = ((longint'(1) << Q7_S) + 7 - 1) / 7;
  localparam int     Q4Y_S  = 29;
  localparam int     Q4Y_PW = DOE_W + 19;
  localparam longint Q4Y_M  = ((longint'(1) << Q4Y_S) + 1460 - 1) / 1460;
  localparam int     Q1C_S  = 34;
  localparam int     Q1C_PW = DOE_W + 19;
  localparam longint Q1C_M  = ((longint'(1) << Q1C_S) + 36524 - 1) / 36524;
  localparam int     QYR_S  = 27;
  localparam int     QYR_PW = DOE_W + 19;
  localparam longint QYR_M  = ((longint'(1) << QYR_S) + 365 - 1) / 365;
  localparam int     QYC_S  = 16;
  localparam int     QYC_PW = YOE_W + 10;
  localparam longint QYC_M  = ((longint'(1) << QYC_S) + 100 - 1) / 100;
  localparam int     QMP_S  = 19;
  localparam int     QMP_PW = 11 + 12;
  localparam longint QMP_M  = ((longint'(1) << QMP_S) + 153 - 1) / 153;

  // Fields carried to the output; weekday and serial are cleared on a failed status
  typedef struct packed {
    logic [WDAY_W-1:0] wd;
    logic [SER_W-1:0]  ser;
    status_t           st;
  } side_t;

  typedef struct packed {
    logic [ABS_W-1:0]  a;
    logic [4:0]        era;
    logic [19:0]       q7;
    logic [SER_W-1:0]  ser;
    status_t           st;
  } s4_t;

  typedef struct packed {
    logic [DOE_W-1:0]  doe;
    logic [4:0]        era;
    side_t             side;
  } s5_t;

  typedef struct packed {
    logic [DOE_W-1:0]  doe;
    logic [7:0]        q4y;
    logic [2:0]        q1c;
    logic              qlast;
    logic [4:0]        era;
    side_t             side;
  } s6_t;

  typedef struct packed {
    logic [DOE_W-1:0]  n;
    logic [DOE_W-1:0]  doe;
    logic [4:0]        era;
    side_t             side;
  } s7_t;

  typedef struct packed {
    logic [YOE_W-1:0]  yoe;
    logic [DOE_W-1:0]  doe;
    logic [4:0]        era;
    side_t             side;
  } s8_t;

  typedef struct packed {
    logic [DOY_W-1:0]  doy;
    logic [YEAR_W-1:0] yy;
    side_t             side;
  } s9_t;

  typedef struct packed {
    logic [3:0]        mp;
    logic [DOY_W-1:0]  doy;
    logic [YEAR_W-1:0] yy;
    side_t             side;
  } s10_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    side_t             side;
  } s11_t;

  s4_t  s4_r,  s4_nxt;
  s5_t  s5_r,  s5_nxt;
  s6_t  s6_r,  s6_nxt;
  s7_t  s7_r,  s7_nxt;
  s8_t  s8_r,  s8_nxt;
  s9_t  s9_r,  s9_nxt;
  s10_t s10_r, s10_nxt;
  s11_t s11_r, s11_nxt;

  logic [ERA_PW-1:0] era_prod;
  logic [Q7_PW-1:0]  q7_prod;
  logic              in_rng;
  logic [22:0]       era_days;
  logic [2:0]        rem7;
  logic [3:0]        wd_sum;
  logic [Q4Y_PW-1:0] q4y_prod;
  logic [Q1C_PW-1:0] q1c_prod;
  logic [QYR_PW-1:0] qyr_prod;
  logic [QYC_PW-1:0] qyc_prod;
  logic [DOE_W-1:0]  yr_days;
  logic [10:0]       mp_num;
  logic [QMP_PW-1:0] qmp_prod;
  logic [MON_W-1:0]  mon;

  // Stage 4: range check, serial number, era and week quotients
  always_comb begin
    in_rng     = (day_i.target >= $signed(SUM_W'(BASE))) &&
                 (day_i.target <= $signed(SUM_W'(LAST)));
    s4_nxt.a   = day_i.target[ABS_W-1:0];
    era_prod   = ERA_PW'(s4_nxt.a) * ERA_PW'(ERA_M);
    q7_prod    = Q7_PW'(s4_nxt.a) * Q7_PW'(Q7_M);
    s4_nxt.era = era_prod[ERA_PW-1:ERA_S];
    s4_nxt.q7  = q7_prod[Q7_PW-1:Q7_S];
    s4_nxt.ser = SER_W'(s4_nxt.a - BASE);
    if (day_i.bad) begin
      s4_nxt.st = ST_BAD_DATE;
    end else if (!in_rng) begin
      s4_nxt.st = ST_RANGE;
    end else begin
      s4_nxt.st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s4_r <= s4_nxt;
  end

  // Stage 5: day of era and weekday
  always_comb begin
    era_days   = 23'(s4_r.era) * 23'(DAYS_PER_ERA);
    s5_nxt.doe = DOE_W'(23'(s4_r.a) - era_days);
    rem7       = 3'(s4_r.a - ABS_W'(s4_r.q7 * 20'd7));
    wd_sum     = 4'(rem7) + 4'd2;
    if (wd_sum >= 4'd7) begin
      wd_sum = wd_sum - 4'd7;
    end
    s5_nxt.era      = s4_r.era;
    s5_nxt.side.wd  = 3'(wd_sum) + 3'd1;
    s5_nxt.side.ser = s4_r.ser;
    s5_nxt.side.st  = s4_r.st;
  end

  always_ff @(posedge clk) begin
    if (en[1]) s5_r <= s5_nxt;
  end

  // Stage 6: leap corrections of the day of era
  always_comb begin
    q4y_prod     = Q4Y_PW'(s5_r.doe) * Q4Y_PW'(Q4Y_M);
    q1c_prod     = Q1C_PW'(s5_r.doe) * Q1C_PW'(Q1C_M);
    s6_nxt.q4y   = q4y_prod[Q4Y_PW-1:Q4Y_S];
    s6_nxt.q1c   = q1c_prod[Q1C_PW-1:Q1C_S];
    s6_nxt.qlast = (s5_r.doe == DOE_W'(DAYS_PER_ERA - 1));
    s6_nxt.doe   = s5_r.doe;
    s6_nxt.era   = s5_r.era;
    s6_nxt.side  = s5_r.side;
  end

  always_ff @(posedge clk) begin
    if (en[2]) s6_r <= s6_nxt;
  end

  // Stage 7: fold the corrections into a 365-day count
  always_comb begin
    s7_nxt.n    = s6_r.doe - DOE_W'(s6_r.q4y) + DOE_W'(s6_r.q1c) - DOE_W'(s6_r.qlast);
    s7_nxt.doe  = s6_r.doe;
    s7_nxt.era  = s6_r.era;
    s7_nxt.side = s6_r.side;
  end

  always_ff @(posedge clk) begin
    if (en[3]) s7_r <= s7_nxt;
  end

  // Stage 8: year of era
  always_comb begin
    qyr_prod    = QYR_PW'(s7_r.n) * QYR_PW'(QYR_M);
    s8_nxt.yoe  = qyr_prod[QYR_S+YOE_W-1:QYR_S];
    s8_nxt.doe  = s7_r.doe;
    s8_nxt.era  = s7_r.era;
    s8_nxt.side = s7_r.side;
  end

  always_ff @(posedge clk) begin
    if (en[4]) s8_r <= s8_nxt;
  end

  // Stage 9: day of the March-based year and full shifted year
  always_comb begin
    qyc_prod    = QYC_PW'(s8_r.yoe) * QYC_PW'(QYC_M);
    yr_days     = DOE_W'(s8_r.yoe) * DOE_W'(365) + DOE_W'(s8_r.yoe >> 2)
                  - DOE_W'(qyc_prod[QYC_PW-1:QYC_S]);
    s9_nxt.doy  = DOY_W'(s8_r.doe - yr_days);
    s9_nxt.yy   = YEAR_W'(s8_r.era) * YEAR_W'(400) + YEAR_W'(s8_r.yoe);
    s9_nxt.side = s8_r.side;
  end

  always_ff @(posedge clk) begin
    if (en[5]) s9_r <= s9_nxt;
  end

  // Stage 10: March-based month
  always_comb begin
    mp_num       = 11'(s9_r.doy) * 11'd5 + 11'd2;
    qmp_prod     = QMP_PW'(mp_num) * QMP_PW'(QMP_M);
    s10_nxt.mp   = qmp_prod[QMP_PW-1:QMP_S];
    s10_nxt.doy  = s9_r.doy;
    s10_nxt.yy   = s9_r.yy;
    s10_nxt.side = s9_r.side;
  end

  always_ff @(posedge clk) begin
    if (en[6]) s10_r <= s10_nxt;
  end

  // Stage 11: calendar day, month and year; clear fields on a failed status
  always_comb begin
    mon = (s10_r.mp < 4'd10) ? s10_r.mp + 4'd3 : s10_r.mp - 4'd9;
    s11_nxt.day   = DAY_W'(s10_r.doy - march_start_f(s10_r.mp) + 9'd1);
    s11_nxt.month = mon;
    s11_nxt.year  = s10_r.yy + YEAR_W'(mon <= 4'd2);
    s11_nxt.side  = s10_r.side;
    if (s10_r.side.st != ST_OK) begin
      s11_nxt.day      = '0;
      s11_nxt.month    = '0;
      s11_nxt.year     = '0;
      s11_nxt.side.wd  = '0;
      s11_nxt.side.ser = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) s11_r <= s11_nxt;
  end

  assign day_out    = s11_r.day;
  assign month_out  = s11_r.month;
  assign year_out   = s11_r.year;
  assign weekday    = s11_r.side.wd;
  assign day_serial = s11_r.side.ser;
  assign status     = s11_r.side.st;

endmodule

/* hdl/calendar_date_offset_top.sv */
`timescale 1ns / 1ps
// A result reaches out_valid through the three forward and eight inverse stages.
// Throughput: one transaction per cycle while out_ready is high; a stage advances
// when it is empty or its successor advances, so bubbles close during output stalls.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is kept.
// ----------------------------------------------------------------------------
// Calendar date offset top level
// Checks a Gregorian date, moves it by a signed number of days and returns
// the new date, weekday, serial day number and status.
// ----------------------------------------------------------------------------
module calendar_date_offset_top
  import cdo_pkg::*;
#(
  parameter int FIRST_YEAR = FIRST_YEAR_DEF,
  parameter int LAST_YEAR  = LAST_YEAR_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DAY_W-1:0]         in_day_in,
  input  logic [MON_W-1:0]         in_month_in,
  input  logic [YEAR_W-1:0]        in_year_in,
  input  logic signed [OFF_W-1:0]  in_day_offset,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DAY_W-1:0]         out_day_out,
  output logic [MON_W-1:0]         out_month_out,
  output logic [YEAR_W-1:0]        out_year_out,
  output logic [WDAY_W-1:0]        out_weekday,
  output logic [SER_W-1:0]         out_day_serial,
  output status_t                  out_status
);

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [STAGES-1:0] stg_en;
  cdo_day_t          fwd_day;

  // Advance a stage when it holds nothing or its successor advances
  always_comb begin
    stg_en[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  // Move valid bits along with the data
  always_comb begin
    vld_nxt = vld_r;
    if (stg_en[0]) vld_nxt[0] = in_valid;
    for (int k = 1; k < STAGES; k++) begin
      if (stg_en[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld_r[STAGES-1];

  cdo_to_day #(
    .FIRST_YEAR (FIRST_YEAR),
    .LAST_YEAR  (LAST_YEAR)
  ) u_to_day (
    .clk    (clk),
    .en     (stg_en[FWD_STAGES-1:0]),
    .day    (in_day_in),
    .month  (in_month_in),
    .year   (in_year_in),
    .offset (in_day_offset),
    .day_o  (fwd_day)
  );

  cdo_from_day #(
    .FIRST_YEAR (FIRST_YEAR),
    .LAST_YEAR  (LAST_YEAR)
  ) u_from_day (
    .clk        (clk),
    .en         (stg_en[STAGES-1:FWD_STAGES]),
    .day_i      (fwd_day),
    .day_out    (out_day_out),
    .month_out  (out_month_out),
    .year_out   (out_year_out),
    .weekday    (out_weekday),
    .day_serial (out_day_serial),
    .status     (out_status)
  );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date offset testbench
// Drives dates with signed day offsets through the valid/ready input channel
// and checks every result against fixed expected values or an in-bench date
// calculator. The run opens with a table of corner dates, then random traffic
// with idling on both sides, a long output hold-off and a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb
  import cdo_pkg::*;
();

  localparam int FIRST_YEAR     = FIRST_YEAR_DEF;
  localparam int LAST_YEAR      = LAST_YEAR_DEF;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_MAX     = 10;

  // One result transaction
  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [WDAY_W-1:0] wday;
    logic [SER_W-1:0]  serial;
    status_t           status;
  } date_res_t;

  // One row of the directed table
  typedef struct {
    logic [DAY_W-1:0]        d;
    logic [MON_W-1:0]        m;
    logic [YEAR_W-1:0]       y;
    logic signed [OFF_W-1:0] off;
    bit                      known;
    date_res_t               res;
  } date_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [DAY_W-1:0]        in_day_in;
  logic [MON_W-1:0]        in_month_in;
  logic [YEAR_W-1:0]       in_year_in;
  logic signed [OFF_W-1:0] in_day_offset;
  logic                    out_valid;
  logic                    out_ready;
  logic [DAY_W-1:0]        out_day_out;
  logic [MON_W-1:0]        out_month_out;
  logic [YEAR_W-1:0]       out_year_out;
  logic [WDAY_W-1:0]       out_weekday;
  logic [SER_W-1:0]        out_day_serial;
  status_t                 out_status;

  date_res_t date_due_q[$];
  date_row_t corner_tab[$];
  date_res_t drv_due;
  date_res_t got_res;
  date_res_t want_res;

  bit quiet;
  bit hold_req;
  int hold_seen;
  int err_cnt;
  int in_cnt;
  int ok_cnt;
  int bad_cnt;
  int range_cnt;
  int idle_cycles;

  calendar_date_offset_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_day_in      (in_day_in),
    .in_month_in    (in_month_in),
    .in_year_in     (in_year_in),
    .in_day_offset  (in_day_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_day_out    (out_day_out),
    .out_month_out  (out_month_out),
    .out_year_out   (out_year_out),
    .out_weekday    (out_weekday),
    .out_day_serial (out_day_serial),
    .out_status     (out_status)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Date calculator
  // ---------------------------------------------------------------------
  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int y, input int m);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Days from FIRST_YEAR-01-01 to the given date
  function automatic int serial_of(input int y, input int m, input int d);
    int n;
    int k;
    int py;
    int fy;
    py = y - 1;
    fy = FIRST_YEAR - 1;
    n = (y - FIRST_YEAR) * 365 + (py / 4 - py / 100 + py / 400)
        - (fy / 4 - fy / 100 + fy / 400);
    for (k = 1; k < m; k++) n += days_in_month(y, k);
    return n + d - 1;
  endfunction

  function automatic date_res_t predict_date(input int d, input int m, input int y,
                                             input int off);
    date_res_t r;
    int t;
    int ry;
    int rm;
    int rem;
    r = '0;
    r.status = ST_OK;
    if (y < FIRST_YEAR || y > LAST_YEAR || m < 1 || m > 12 ||
        d < 1 || d > days_in_month(y, m)) begin
      r.status = ST_BAD_DATE;
      return r;
    end
    t = serial_of(y, m, d) + off;
    if (t < 0 || t > serial_of(LAST_YEAR, 12, 31)) begin
      r.status = ST_RANGE;
      return r;
    end
    // Undershoot the year, then step up to the one holding the target
    ry = FIRST_YEAR + t / 366;
    while (serial_of(ry + 1, 1, 1) <= t) ry++;
    rem = t - serial_of(ry, 1, 1);
    rm = 1;
    while (rem >= days_in_month(ry, rm)) begin
      rem -= days_in_month(ry, rm);
      rm++;
    end
    r.day    = DAY_W'(rem + 1);
    r.month  = MON_W'(rm);
    r.year   = YEAR_W'(ry);
    r.wday   = WDAY_W'((t + 2) % 7 + 1);
    r.serial = SER_W'(t);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_row(input int d, input int m, input int y, input int off);
    date_row_t row;
    row.d     = DAY_W'(d);
    row.m     = MON_W'(m);
    row.y     = YEAR_W'(y);
    row.off   = OFF_W'(off);
    row.known = 1'b0;
    row.res   = '0;
    corner_tab.push_back(row);
  endtask

  task automatic add_row_known(input int d, input int m, input int y, input int off,
                               input int ed, input int em, input int ey,
                               input int ew, input int es, input status_t st);
    date_row_t row;
    row.d          = DAY_W'(d);
    row.m          = MON_W'(m);
    row.y          = YEAR_W'(y);
    row.off        = OFF_W'(off);
    row.known      = 1'b1;
    row.res.day    = DAY_W'(ed);
    row.res.month  = MON_W'(em);
    row.res.year   = YEAR_W'(ey);
    row.res.wday   = WDAY_W'(ew);
    row.res.serial = SER_W'(es);
    row.res.status = st;
    corner_tab.push_back(row);
  endtask

  // Offer one transaction, hold it until accepted, then maybe idle
  task automatic drive_date(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                            input logic [YEAR_W-1:0] y,
                            input logic signed [OFF_W-1:0] off,
                            input bit known, input date_res_t typed);
    in_valid      <= 1'b1;
    in_day_in     <= d;
    in_month_in   <= m;
    in_year_in    <= y;
    in_day_offset <= off;
    drv_due       <= known ? typed : predict_date(int'(d), int'(m), int'(y), int'(off));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_dates(input int n);
    int k;
    int r;
    int yy;
    int mm;
    int dd;
    int off;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // Raw field noise, mostly invalid dates
        drive_date(DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom),
                   OFF_W'($urandom), 1'b0, '0);
      end else begin
        if (r < 20) begin
          yy = $urandom_range(1) ? $urandom_range(FIRST_YEAR, FIRST_YEAR + 5)
                                 : $urandom_range(LAST_YEAR - 5, LAST_YEAR);
        end else begin
          yy = $urandom_range(FIRST_YEAR, LAST_YEAR);
        end
        mm = $urandom_range(1, 12);
        dd = (r < 30) ? days_in_month(yy, mm) : $urandom_range(1, days_in_month(yy, mm));
        r = $urandom_range(99);
        if (r < 30) begin
          off = $urandom_range(800) - 400;
        end else if (r < 60) begin
          off = $urandom_range(200000) - 100000;
        end else begin
          off = int'($signed(OFF_W'($urandom)));
        end
        drive_date(DAY_W'(dd), MON_W'(mm), YEAR_W'(yy), OFF_W'(off), 1'b0, '0);
      end
    end
  endtask

  // Stop offering and wait for the pipeline to empty
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (date_due_q.size() != 0) @(posedge clk);
    repeat (STAGES + 4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        hold_seen++;
      end else begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check results, record accepted inputs, watchdog
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_res.day    = out_day_out;
        got_res.month  = out_month_out;
        got_res.year   = out_year_out;
        got_res.wday   = out_weekday;
        got_res.serial = out_day_serial;
        got_res.status = out_status;
        if (date_due_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("ERROR: unexpected result %0d-%0d-%0d wd %0d serial %0d status %0d",
                     got_res.year, got_res.month, got_res.day, got_res.wday,
                     got_res.serial, got_res.status);
        end else begin
          want_res = date_due_q.pop_front();
          case (want_res.status)
            ST_OK:       ok_cnt++;
            ST_BAD_DATE: bad_cnt++;
            default:     range_cnt++;
          endcase
          if (got_res.day != want_res.day || got_res.month != want_res.month ||
              got_res.year != want_res.year || got_res.wday != want_res.wday ||
              got_res.serial != want_res.serial || got_res.status != want_res.status) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $display({"ERROR: expected %0d-%0d-%0d wd %0d serial %0d status %0d, ",
                        "got %0d-%0d-%0d wd %0d serial %0d status %0d"},
                       want_res.year, want_res.month, want_res.day, want_res.wday,
                       want_res.serial, want_res.status,
                       got_res.year, got_res.month, got_res.day, got_res.wday,
                       got_res.serial, got_res.status);
          end
        end
      end
      if (in_valid && in_ready) begin
        date_due_q.push_back(drv_due);
        in_cnt++;
      end
      // Count cycles in which no transaction moves
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles, %0d results pending",
                 idle_cycles, date_due_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_day_in     <= '0;
    in_month_in   <= '0;
    in_year_in    <= '0;
    in_day_offset <= '0;
    drv_due       <= '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    hold_seen = 0;
    err_cnt   = 0;
    in_cnt    = 0;
    ok_cnt    = 0;
    bad_cnt   = 0;
    range_cnt = 0;
    idle_cycles = 0;

    // Corner dates with results that are plain to see
    add_row_known(1, 1, 1800, 0, 1, 1, 1800, 3, 0, ST_OK);
    add_row_known(31, 12, 9999, 0, 31, 12, 9999, 5, 2994987, ST_OK);
    add_row_known(1, 1, 1800, -1, 0, 0, 0, 0, 0, ST_RANGE);
    add_row_known(31, 12, 9999, 1, 0, 0, 0, 0, 0, ST_RANGE);
    add_row_known(1, 1, 1800, -2097152, 0, 0, 0, 0, 0, ST_RANGE);
    add_row_known(31, 12, 9999, 2097151, 0, 0, 0, 0, 0, ST_RANGE);
    add_row_known(0, 1, 2000, 0, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(31, 4, 2000, 0, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(29, 2, 1900, 1, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(1, 0, 2000, 0, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(1, 13, 2000, 0, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(1, 1, 1799, 1, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(1, 1, 10000, -1, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(31, 15, 16383, -1, 0, 0, 0, 0, 0, ST_BAD_DATE);
    add_row_known(0, 0, 0, 0, 0, 0, 0, 0, 0, ST_BAD_DATE);
    // Leap days, month and year boundaries, offset extremes
    add_row(29, 2, 2000, 0);
    add_row(28, 2, 2000, 1);
    add_row(28, 2, 1900, 1);
    add_row(1, 3, 2000, -1);
    add_row(31, 12, 1899, 1);
    add_row(15, 6, 5000, 2097151);
    add_row(15, 6, 5000, -2097152);
    add_row(1, 1, 1800, 2097151);
    add_row(31, 12, 9999, -2097152);
    add_row(1, 1, 1800, 2994987);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the corner table
    foreach (corner_tab[i])
      drive_date(corner_tab[i].d, corner_tab[i].m, corner_tab[i].y, corner_tab[i].off,
                 corner_tab[i].known, corner_tab[i].res);
    drain_results();

    // Random traffic with idling on both sides
    send_random_dates(400);

    // Hold the result side off while inputs keep coming
    hold_req = 1'b1;
    send_random_dates(300);
    drain_results();

    // Back-to-back stretch, no idling anywhere
    quiet = 1'b1;
    send_random_dates(300);
    quiet = 1'b0;

    send_random_dates(250);
    drain_results();

    err_cnt += date_due_q.size();
    $display("Checked %0d transactions: %0d moved dates, %0d invalid dates, %0d out of range",
             in_cnt, ok_cnt, bad_cnt, range_cnt);
    $display("Covered corner dates, random idling, %0d output hold-off(s), back-to-back",
             hold_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/cdo_pkg.sv
hdl/cdo_to_day.sv
hdl/cdo_from_day.sv
hdl/calendar_date_offset_top.sv
sim/tb.sv
